### rtl/dsi2d_pkg.sv
// Types, register indexes and arithmetic step functions for the damped
// spring impulse block. Depends on nothing; used by damped_spring_impulse_2d.
package dsi2d_pkg;

  localparam int REG_W     = 31;
  localparam int VAL_W     = 32;
  localparam int RAD_W     = 66;
  localparam int ROOT_W    = 33;
  localparam int SQ_STEPS  = 33;
  localparam int DIV_STEPS = 17;
  localparam int QUO_W     = 17;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_STIFFNESS = 2'd0;
  localparam reg_idx_t REG_DAMPING   = 2'd1;
  localparam reg_idx_t REG_REST      = 2'd2;
  localparam reg_idx_t REG_TIME_STEP = 2'd3;

  localparam logic [REG_W-1:0] RST_STIFFNESS = 31'd65536;
  localparam logic [REG_W-1:0] RST_DAMPING   = 31'd0;
  localparam logic [REG_W-1:0] RST_REST      = 31'd65536;
  localparam logic [REG_W-1:0] RST_TIME_STEP = 31'd1092;

  // Item data that rides along the length and direction stages.
  typedef struct packed {
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic               sx;
    logic               sy;
    logic signed [32:0] vx;
    logic signed [32:0] vy;
    logic               p1;
    logic               p2;
    logic               coinc;
  } carry_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [35:0]       rem;
    logic [ROOT_W-1:0] root;
    carry_t            c;
  } sqrt_t;

  typedef struct packed {
    logic [ROOT_W-1:0] len;
    logic [32:0]       remx;
    logic [32:0]       remy;
    logic [QUO_W-1:0]  qx;
    logic [QUO_W-1:0]  qy;
    carry_t            c;
  } div_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } clip_t;

  // One digit of the restoring square root: two radicand bits in, one root bit out.
  function automatic sqrt_t sqrt_step(sqrt_t s, logic [1:0] pair);
    sqrt_t       o;
    logic [35:0] rr;
    logic [35:0] t;
    o  = s;
    rr = {s.rem[33:0], pair};
    t  = {1'b0, s.root, 2'b01};
    if (rr >= t) begin
      o.rem  = rr - t;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = rr;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // One quotient bit of both direction components.
  function automatic div_t div_step(div_t d, logic bx, logic by);
    div_t        o;
    logic [33:0] rx;
    logic [33:0] ry;
    logic [33:0] l;
    o  = d;
    rx = {d.remx, bx};
    ry = {d.remy, by};
    l  = {1'b0, d.len};
    if (rx >= l) begin
      o.remx = 33'(rx - l);
      o.qx   = {d.qx[QUO_W-2:0], 1'b1};
    end else begin
      o.remx = rx[32:0];
      o.qx   = {d.qx[QUO_W-2:0], 1'b0};
    end
    if (ry >= l) begin
      o.remy = 33'(ry - l);
      o.qy   = {d.qy[QUO_W-2:0], 1'b1};
    end else begin
      o.remy = ry[32:0];
      o.qy   = {d.qy[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // Signed saturation of a sign and magnitude to 32 bits.
  function automatic clip_t clip32(logic [64:0] mag, logic neg);
    clip_t o;
    if (neg) begin
      o.sat = (mag[64:32] != '0) || (mag[31] && (mag[30:0] != '0));
      o.val = o.sat ? 32'h8000_0000 : 32'(-mag[31:0]);
    end else begin
      o.sat = (mag[64:31] != '0);
      o.val = o.sat ? 32'h7FFF_FFFF : mag[31:0];
    end
    return o;
  endfunction

endpackage

### rtl/damped_spring_impulse_2d.sv
// Top level of the damped spring impulse block: a 58-stage pipeline.
// Depends on dsi2d_pkg for types, register indexes and step functions.
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/in_stall   | contact points, velocities, presence
//  out_    | output    | out_valid/out_stall | impulse, apply flags, coincident, saturated
//  cfg_    | input     | cfg_we              | cfg_index, cfg_data
//
// A beat can enter every cycle unless in_stall is high.
// The depth is set by the bit-per-stage square root (33 stages) and the
// bit-per-stage direction divider (17 stages), plus eight arithmetic stages.
// rst_n is synchronous and clears all valid bits and the registers to defaults.
// When out_stall holds a waiting result, every stage holds and in_stall rises.
// A beat with neither body present is taken but gives no result.
module damped_spring_impulse_2d (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_first_x,
  input  logic signed [31:0] in_first_y,
  input  logic signed [31:0] in_second_x,
  input  logic signed [31:0] in_second_y,
  input  logic signed [31:0] in_first_vel_x,
  input  logic signed [31:0] in_first_vel_y,
  input  logic signed [31:0] in_second_vel_x,
  input  logic signed [31:0] in_second_vel_y,
  input  logic               in_first_present,
  input  logic               in_second_present,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_impulse_x,
  output logic signed [31:0] out_impulse_y,
  output logic               out_apply_first,
  output logic               out_apply_second,
  output logic               out_coincident,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  logic [30:0] stiffness_r;
  logic [30:0] damping_r;
  logic [30:0] rest_r;
  logic [30:0] dt_r;

  logic adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiffness_r <= dsi2d_pkg::RST_STIFFNESS;
      damping_r   <= dsi2d_pkg::RST_DAMPING;
      rest_r      <= dsi2d_pkg::RST_REST;
      dt_r        <= dsi2d_pkg::RST_TIME_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsi2d_pkg::REG_STIFFNESS: stiffness_r <= cfg_data;
        dsi2d_pkg::REG_DAMPING:   damping_r   <= cfg_data;
        dsi2d_pkg::REG_REST:      rest_r      <= cfg_data;
        dsi2d_pkg::REG_TIME_STEP: dt_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Entry stage: differences, magnitudes and velocity selection.
  dsi2d_pkg::carry_t c0_nxt, c0_r;
  logic              v0_r;
  logic signed [32:0] dx, dy;

  always_comb begin
    dx = 33'(in_second_x) - 33'(in_first_x);
    dy = 33'(in_second_y) - 33'(in_first_y);
    c0_nxt.sx    = dx[32];
    c0_nxt.sy    = dy[32];
    c0_nxt.ax    = dx[32] ? 32'(-dx) : dx[31:0];
    c0_nxt.ay    = dy[32] ? 32'(-dy) : dy[31:0];
    c0_nxt.coinc = (dx == '0) && (dy == '0);
    c0_nxt.p1    = in_first_present;
    c0_nxt.p2    = in_second_present;
    if (!in_first_present) begin
      c0_nxt.vx = 33'(in_second_vel_x);
      c0_nxt.vy = 33'(in_second_vel_y);
    end else if (!in_second_present) begin
      c0_nxt.vx = 33'(in_first_vel_x);
      c0_nxt.vy = 33'(in_first_vel_y);
    end else begin
      c0_nxt.vx = 33'(in_second_vel_x) - 33'(in_first_vel_x);
      c0_nxt.vy = 33'(in_second_vel_y) - 33'(in_first_vel_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid && (in_first_present || in_second_present);
      c0_r <= c0_nxt;
    end
  end

  // Squares, then their sum.
  logic [63:0]       sqx_r, sqy_r;
  dsi2d_pkg::carry_t c1_r, c2_r;
  logic              v1_r, v2_r;
  logic [dsi2d_pkg::RAD_W-1:0] rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r  <= v0_r;
      c1_r  <= c0_r;
      sqx_r <= c0_r.ax * c0_r.ax;
      sqy_r <= c0_r.ay * c0_r.ay;
      v2_r  <= v1_r;
      c2_r  <= c1_r;
      rad_r <= {1'b0, {1'b0, sqx_r} + {1'b0, sqy_r}};
    end
  end

  // Square root, one root bit per stage.
  dsi2d_pkg::sqrt_t sq_r [dsi2d_pkg::SQ_STEPS];
  logic             sv_r [dsi2d_pkg::SQ_STEPS];
  dsi2d_pkg::sqrt_t sq_init;

  always_comb begin
    sq_init.rad  = rad_r;
    sq_init.rem  = '0;
    sq_init.root = '0;
    sq_init.c    = c2_r;
  end

  for (genvar i = 0; i < dsi2d_pkg::SQ_STEPS; i++) begin : g_sqrt
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sv_r[i] <= 1'b0;
        end else if (adv) begin
          sv_r[i] <= v2_r;
          sq_r[i] <= dsi2d_pkg::sqrt_step(sq_init, rad_r[dsi2d_pkg::RAD_W-1 -: 2]);
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sv_r[i] <= 1'b0;
        end else if (adv) begin
          sv_r[i] <= sv_r[i-1];
          sq_r[i] <= dsi2d_pkg::sqrt_step(sq_r[i-1],
                                          sq_r[i-1].rad[dsi2d_pkg::RAD_W-1-2*i -: 2]);
        end
      end
    end
  end

  // Direction divider: quotient is at most one in Q16.16, so 17 bits suffice
  // and the partial remainder starts from the magnitude halved.
  dsi2d_pkg::div_t dv_r [dsi2d_pkg::DIV_STEPS];
  logic            dvv_r [dsi2d_pkg::DIV_STEPS];
  dsi2d_pkg::div_t dv_init;
  dsi2d_pkg::sqrt_t sq_last;

  always_comb begin
    sq_last      = sq_r[dsi2d_pkg::SQ_STEPS-1];
    dv_init.len  = sq_last.root;
    dv_init.remx = {2'b00, sq_last.c.ax[31:1]};
    dv_init.remy = {2'b00, sq_last.c.ay[31:1]};
    dv_init.qx   = '0;
    dv_init.qy   = '0;
    dv_init.c    = sq_last.c;
  end

  for (genvar j = 0; j < dsi2d_pkg::DIV_STEPS; j++) begin : g_div
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dvv_r[j] <= 1'b0;
        end else if (adv) begin
          dvv_r[j] <= sv_r[dsi2d_pkg::SQ_STEPS-1];
          dv_r[j]  <= dsi2d_pkg::div_step(dv_init, sq_last.c.ax[0], sq_last.c.ay[0]);
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dvv_r[j] <= 1'b0;
        end else if (adv) begin
          dvv_r[j] <= dvv_r[j-1];
          dv_r[j]  <= dsi2d_pkg::div_step(dv_r[j-1], 1'b0, 1'b0);
        end
      end
    end
  end

  // Arithmetic stages in sign and magnitude, each product truncated toward zero.
  dsi2d_pkg::div_t dv_last;
  logic [16:0]        ux_mag, uy_mag;
  logic signed [33:0] stretch;
  logic [31:0]        vxm, vym;
  logic [47:0]        kx_prod, ky_prod;
  logic [62:0]        bx_prod, by_prod;

  always_comb begin
    dv_last = dv_r[dsi2d_pkg::DIV_STEPS-1];
    ux_mag  = dv_last.c.coinc ? '0 : dv_last.qx;
    uy_mag  = dv_last.c.coinc ? '0 : dv_last.qy;
    kx_prod = ux_mag * stiffness_r;
    ky_prod = uy_mag * stiffness_r;
    stretch = $signed({3'b000, rest_r}) - $signed({1'b0, dv_last.len});
    vxm     = dv_last.c.vx[32] ? 32'(-dv_last.c.vx) : dv_last.c.vx[31:0];
    vym     = dv_last.c.vy[32] ? 32'(-dv_last.c.vy) : dv_last.c.vy[31:0];
    bx_prod = damping_r * vxm;
    by_prod = damping_r * vym;
  end

  logic        m1v_r, m2v_r, m3v_r, m4v_r;
  logic [31:0] m1_ax_r, m1_ay_r;
  logic        m1_sx_r, m1_sy_r, m1_stneg_r;
  logic [32:0] m1_st_r;
  logic [46:0] m1_dx_r, m1_dy_r, m2_dx_r, m2_dy_r;
  logic        m1_dxneg_r, m1_dyneg_r, m2_dxneg_r, m2_dyneg_r;
  logic [48:0] m2_spx_r, m2_spy_r;
  logic        m2_sxneg_r, m2_syneg_r;
  logic [49:0] m3_fx_r, m3_fy_r;
  logic        m3_fxneg_r, m3_fyneg_r, m4_fxneg_r, m4_fyneg_r;
  logic [55:0] m4_lox_r, m4_hix_r, m4_loy_r, m4_hiy_r;
  logic [2:0]  m1_fl_r, m2_fl_r, m3_fl_r, m4_fl_r;

  logic [64:0] spx_prod, spy_prod;
  logic signed [50:0] fx, fy;

  always_comb begin
    spx_prod = m1_ax_r * m1_st_r;
    spy_prod = m1_ay_r * m1_st_r;
    fx = (m2_sxneg_r ? -$signed({2'b00, m2_spx_r}) : $signed({2'b00, m2_spx_r}))
       - (m2_dxneg_r ? -$signed({4'b0000, m2_dx_r}) : $signed({4'b0000, m2_dx_r}));
    fy = (m2_syneg_r ? -$signed({2'b00, m2_spy_r}) : $signed({2'b00, m2_spy_r}))
       - (m2_dyneg_r ? -$signed({4'b0000, m2_dy_r}) : $signed({4'b0000, m2_dy_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1v_r <= 1'b0;
      m2v_r <= 1'b0;
      m3v_r <= 1'b0;
      m4v_r <= 1'b0;
    end else if (adv) begin
      m1v_r      <= dvv_r[dsi2d_pkg::DIV_STEPS-1];
      m1_ax_r    <= kx_prod[47:16];
      m1_ay_r    <= ky_prod[47:16];
      m1_sx_r    <= dv_last.c.sx;
      m1_sy_r    <= dv_last.c.sy;
      m1_stneg_r <= stretch[33];
      m1_st_r    <= stretch[33] ? 33'(-stretch) : stretch[32:0];
      m1_dx_r    <= bx_prod[62:16];
      m1_dy_r    <= by_prod[62:16];
      m1_dxneg_r <= dv_last.c.vx[32];
      m1_dyneg_r <= dv_last.c.vy[32];
      m1_fl_r    <= {dv_last.c.p1, dv_last.c.p2, dv_last.c.coinc};

      m2v_r      <= m1v_r;
      m2_spx_r   <= spx_prod[64:16];
      m2_spy_r   <= spy_prod[64:16];
      m2_sxneg_r <= m1_sx_r ^ m1_stneg_r;
      m2_syneg_r <= m1_sy_r ^ m1_stneg_r;
      m2_dx_r    <= m1_dx_r;
      m2_dy_r    <= m1_dy_r;
      m2_dxneg_r <= m1_dxneg_r;
      m2_dyneg_r <= m1_dyneg_r;
      m2_fl_r    <= m1_fl_r;

      m3v_r      <= m2v_r;
      m3_fxneg_r <= fx[50];
      m3_fyneg_r <= fy[50];
      m3_fx_r    <= fx[50] ? 50'(-fx) : fx[49:0];
      m3_fy_r    <= fy[50] ? 50'(-fy) : fy[49:0];
      m3_fl_r    <= m2_fl_r;

      // The force magnitude is split in two halves against the time step.
      m4v_r      <= m3v_r;
      m4_lox_r   <= m3_fx_r[24:0] * dt_r;
      m4_hix_r   <= m3_fx_r[49:25] * dt_r;
      m4_loy_r   <= m3_fy_r[24:0] * dt_r;
      m4_hiy_r   <= m3_fy_r[49:25] * dt_r;
      m4_fxneg_r <= m3_fxneg_r;
      m4_fyneg_r <= m3_fyneg_r;
      m4_fl_r    <= m3_fl_r;
    end
  end

  // Output register.
  logic [80:0]      totx, toty;
  dsi2d_pkg::clip_t clx, cly;
  logic [31:0]      imp_x_r, imp_y_r;
  logic             apply_first_r, apply_second_r, coinc_r, sat_r;

  always_comb begin
    totx = {m4_hix_r, 25'b0} + {25'b0, m4_lox_r};
    toty = {m4_hiy_r, 25'b0} + {25'b0, m4_loy_r};
    clx  = dsi2d_pkg::clip32(totx[80:16], m4_fxneg_r);
    cly  = dsi2d_pkg::clip32(toty[80:16], m4_fyneg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r    <= m4v_r;
      imp_x_r        <= clx.val;
      imp_y_r        <= cly.val;
      sat_r          <= clx.sat || cly.sat;
      apply_first_r  <= m4_fl_r[2];
      apply_second_r <= m4_fl_r[1];
      coinc_r        <= m4_fl_r[0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_impulse_x    = imp_x_r;
  assign out_impulse_y    = imp_y_r;
  assign out_apply_first  = apply_first_r;
  assign out_apply_second = apply_second_r;
  assign out_coincident   = coinc_r;
  assign out_saturated    = sat_r;

endmodule

### test/damped_spring_impulse_2d_tb.sv
// Self-checking testbench for damped_spring_impulse_2d: random and directed
// spring beats checked against a Q16.16 impulse predictor. Depends on dsi2d_pkg.
`timescale 1ns / 1ps

module damped_spring_impulse_2d_tb;

  typedef struct packed {
    logic signed [31:0] x1, y1, x2, y2, v1x, v1y, v2x, v2y;
    logic               p1, p2;
  } spring_t;

  typedef struct packed {
    logic signed [31:0] jx, jy;
    logic               a1, a2, coinc, sat;
  } impulse_t;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  spring_t in_beat = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  impulse_t got;
  logic cfg_we = 1'b0;
  dsi2d_pkg::reg_idx_t cfg_index = dsi2d_pkg::REG_STIFFNESS;
  logic [30:0] cfg_data = '0;

  spring_t  pending[$];
  impulse_t expected_impulses[$];
  logic [30:0] k_reg, b_reg, rest_reg, dt_reg;
  int  errors = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_off = 0;

  always #5 clk = ~clk;

  damped_spring_impulse_2d u_top (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_first_x(in_beat.x1), .in_first_y(in_beat.y1),
    .in_second_x(in_beat.x2), .in_second_y(in_beat.y2),
    .in_first_vel_x(in_beat.v1x), .in_first_vel_y(in_beat.v1y),
    .in_second_vel_x(in_beat.v2x), .in_second_vel_y(in_beat.v2y),
    .in_first_present(in_beat.p1), .in_second_present(in_beat.p2),
    .out_valid, .out_stall,
    .out_impulse_x(got.jx), .out_impulse_y(got.jy),
    .out_apply_first(got.a1), .out_apply_second(got.a2),
    .out_coincident(got.coinc), .out_saturated(got.sat),
    .cfg_we, .cfg_index, .cfg_data
  );

  // Q16.16 multiply on sign and magnitude, truncated, clamped to 2^62.
  function automatic logic signed [63:0] q_mul(logic signed [63:0] a, logic signed [63:0] b);
    logic [63:0]  ma, mb, r;
    logic [127:0] p;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    p  = ma * mb;
    r  = (p[127:80] != 0) ? 64'h4000_0000_0000_0000 : p[79:16];
    if (r > 64'h4000_0000_0000_0000) r = 64'h4000_0000_0000_0000;
    return (a[63] ^ b[63]) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [31:0] clamp32(logic signed [63:0] v, inout logic sat);
    if (v > 64'sh7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] isqrt(logic [66:0] s);
    logic [63:0]  lo, hi, mid;
    lo = 0;
    hi = 64'd1 << 34;
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >> 1);
      if (134'(mid) * 134'(mid) <= 134'(s)) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic signed [63:0] dir_part(logic signed [63:0] d, logic [63:0] len);
    logic [63:0] q;
    q = ((d[63] ? -d : d) << 16) / len;
    return d[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic impulse_t spring_impulse(spring_t s);
    impulse_t r;
    logic signed [63:0] dx, dy, vx, vy, ux, uy, stretch, fx, fy;
    logic [63:0] len, ax, ay;
    logic sat;
    sat = 1'b0;
    dx = 64'(s.x2) - 64'(s.x1);
    dy = 64'(s.y2) - 64'(s.y1);
    ax = dx[63] ? -dx : dx;
    ay = dy[63] ? -dy : dy;
    len = isqrt(67'(ax) * 67'(ax) + 67'(ay) * 67'(ay));
    r.coinc = (dx == 0) && (dy == 0);
    ux = r.coinc ? 64'sd0 : dir_part(dx, len);
    uy = r.coinc ? 64'sd0 : dir_part(dy, len);
    if (!s.p1) begin
      vx = 64'(s.v2x); vy = 64'(s.v2y);
    end else if (!s.p2) begin
      vx = 64'(s.v1x); vy = 64'(s.v1y);
    end else begin
      vx = 64'(s.v2x) - 64'(s.v1x);
      vy = 64'(s.v2y) - 64'(s.v1y);
    end
    stretch = $signed({33'd0, rest_reg}) - $signed(len);
    fx = q_mul(q_mul(ux, {33'd0, k_reg}), stretch) - q_mul({33'd0, b_reg}, vx);
    fy = q_mul(q_mul(uy, {33'd0, k_reg}), stretch) - q_mul({33'd0, b_reg}, vy);
    r.jx = clamp32(q_mul(fx, {33'd0, dt_reg}), sat);
    r.jy = clamp32(q_mul(fy, {33'd0, dt_reg}), sat);
    r.a1 = s.p1;
    r.a2 = s.p2;
    r.sat = sat;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return 32'h8000_0000 + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
    endcase
  endfunction

  function automatic spring_t rand_spring();
    spring_t s;
    s.x1 = rand_coord(); s.y1 = rand_coord();
    s.x2 = ($urandom_range(0, 9) == 0) ? s.x1 : rand_coord();
    s.y2 = ($urandom_range(0, 9) == 0) ? s.y1 : rand_coord();
    s.v1x = rand_coord(); s.v1y = rand_coord();
    s.v2x = rand_coord(); s.v2y = rand_coord();
    s.p1 = 1'($urandom_range(0, 1));
    s.p2 = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // Driver: one beat per pending item, random gap after each accepted beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (in_beat.p1 || in_beat.p2) expected_impulses.push_back(spring_impulse(in_beat));
        send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          in_beat  <= pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat and varies the receiver stall.
  always @(posedge clk) begin
    impulse_t want;
    if (rst_n) begin
      if (in_valid && !in_stall || out_valid && !out_stall) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && !out_stall) begin
        if (expected_impulses.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          want = expected_impulses.pop_front();
          if (want !== got) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors++;
          end
        end
        recv_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
      end
      if (hold_off > 0) begin
        hold_off--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("damped_spring_impulse_2d_tb failed");
        $finish;
      end
    end
  end

  // Each write drops the enable again before it returns, so writes are kept apart.
  task automatic write_reg(dsi2d_pkg::reg_idx_t idx, logic [30:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dsi2d_pkg::REG_STIFFNESS: k_reg    = val;
      dsi2d_pkg::REG_DAMPING:   b_reg    = val;
      dsi2d_pkg::REG_REST:      rest_reg = val;
      default:                  dt_reg   = val;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || expected_impulses.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    spring_t s;
    k_reg = dsi2d_pkg::RST_STIFFNESS; b_reg = dsi2d_pkg::RST_DAMPING;
    rest_reg = dsi2d_pkg::RST_REST; dt_reg = dsi2d_pkg::RST_TIME_STEP;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats under reset settings: extremes, coincident points, each
    // presence combination including the one that yields nothing.
    s = '0; s.p1 = 1; s.p2 = 1; pending.push_back(s);
    s.x2 = 32'sh0002_0000; pending.push_back(s);
    s.p1 = 0; pending.push_back(s);
    s.p1 = 1; s.p2 = 0; pending.push_back(s);
    s.p1 = 0; pending.push_back(s);
    s = '0; s.p1 = 1; s.p2 = 1;
    s.x1 = 32'h8000_0000; s.y1 = 32'h8000_0000;
    s.x2 = 32'h7FFF_FFFF; s.y2 = 32'h7FFF_FFFF;
    s.v1x = 32'h8000_0000; s.v2x = 32'h7FFF_FFFF;
    s.v1y = 32'h7FFF_FFFF; s.v2y = 32'h8000_0000;
    pending.push_back(s);
    s.x2 = s.x1; s.y2 = s.y1; pending.push_back(s);
    s.x1 = 32'hFFFF_FFFF; s.y1 = 32'h0000_0001; s.x2 = 32'h0; s.y2 = 32'h0;
    pending.push_back(s);
    drain();

    write_reg(dsi2d_pkg::REG_STIFFNESS, 31'h7FFF_FFFF);
    write_reg(dsi2d_pkg::REG_DAMPING, 31'h7FFF_FFFF);
    write_reg(dsi2d_pkg::REG_REST, 31'h7FFF_FFFF);
    write_reg(dsi2d_pkg::REG_TIME_STEP, 31'h7FFF_FFFF);
    pending.push_back(s);
    s.x1 = 32'h8000_0000; s.x2 = 32'h7FFF_FFFF; pending.push_back(s);
    for (int i = 0; i < 6; i++) pending.push_back(rand_spring());
    drain();

    write_reg(dsi2d_pkg::REG_STIFFNESS, '0);
    write_reg(dsi2d_pkg::REG_DAMPING, '0);
    write_reg(dsi2d_pkg::REG_REST, '0);
    write_reg(dsi2d_pkg::REG_TIME_STEP, '0);
    for (int i = 0; i < 6; i++) pending.push_back(rand_spring());
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      write_reg(dsi2d_pkg::REG_STIFFNESS, $urandom_range(0, 3) == 0 ?
                31'($urandom) : 31'($urandom_range(0, 1 << 20)));
      write_reg(dsi2d_pkg::REG_DAMPING, $urandom_range(0, 3) == 0 ?
                31'($urandom) : 31'($urandom_range(0, 1 << 18)));
      write_reg(dsi2d_pkg::REG_REST, $urandom_range(0, 3) == 0 ?
                31'($urandom) : 31'($urandom_range(0, 1 << 20)));
      write_reg(dsi2d_pkg::REG_TIME_STEP, $urandom_range(0, 3) == 0 ?
                31'($urandom) : 31'($urandom_range(0, 1 << 12)));
      for (int i = 0; i < 140; i++) pending.push_back(rand_spring());
      if (phase == 2) begin
        wait (pending.size() < 120);
        hold_off = 300;
      end
      drain();
    end

    if (errors == 0) begin
      $display("damped_spring_impulse_2d_tb passed");
    end else begin
      $display("damped_spring_impulse_2d_tb failed");
    end
    $finish;
  end

endmodule
